[src/three_axis_attitude_pid_macros.svh]
// ----------------------------------------------------------------------------
// three_axis_attitude_pid_macros.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef THREE_AXIS_ATTITUDE_PID_MACROS_SVH
`define THREE_AXIS_ATTITUDE_PID_MACROS_SVH

// same-cycle implication, disabled in reset
`define TAP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define TAP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/tap_pkg.sv]
// ----------------------------------------------------------------------------
// tap_pkg
// Types and constants of the three-axis attitude PID.
// ----------------------------------------------------------------------------
package tap_pkg;

    localparam int ANGLE_FRAC_BITS = 7;
    localparam int GAIN_FRAC_BITS  = 20;

    localparam int ANGLE_W  = 16;
    localparam int GAIN_W   = 20;
    localparam int GAINS_W  = 3 * GAIN_W;
    localparam int ACC_W    = 48;
    localparam int OUT_W    = 32;
    localparam int HEAD_W   = 9;
    localparam int OUT_FRAC = 16;
    localparam int TOTAL_FRAC = ANGLE_FRAC_BITS + GAIN_FRAC_BITS;

    // error width: plain angle difference or scaled whole-degree yaw error
    localparam int ERR_W = (ANGLE_W + 1 > HEAD_W + ANGLE_FRAC_BITS) ?
                           ANGLE_W + 1 : HEAD_W + ANGLE_FRAC_BITS;

    localparam int IN_TDATA_W  = 6 * ANGLE_W;
    localparam int OUT_FIELD_W = 3 * OUT_W + HEAD_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROLL    = 2'd0,
        CFG_PITCH   = 2'd1,
        CFG_HEADING = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
    } t_gains;

    localparam logic [GAINS_W-1:0] GAINS_RESET = 60'd103763111380516874;

    typedef struct packed {
        logic signed [ERR_W-1:0]  roll;
        logic signed [ERR_W-1:0]  pitch;
        logic signed [HEAD_W-1:0] head;
    } t_err;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic load_c;
    } t_pipe_ctl;

endpackage

[src/tap_front.sv]
// ----------------------------------------------------------------------------
// tap_front
// Takes input beats, forms roll/pitch errors and the wrapped yaw error.
// ----------------------------------------------------------------------------
module tap_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [tap_pkg::IN_TDATA_W-1:0] i_data,
    output logic                           o_valid,
    input  logic                           i_ready,
    output tap_pkg::t_err                  o_err
);
    import tap_pkg::*;

    localparam int DEG_W = ANGLE_W - ANGLE_FRAC_BITS;
    localparam int D_W   = DEG_W + 1;
    localparam int J     = (D_W > 7) ? D_W - 7 : 0;
    localparam int U_W   = 11 + J;
    localparam logic [ANGLE_W-1:0] FRAC_MASK = ANGLE_W'((1 << ANGLE_FRAC_BITS) - 1);

    logic                         r_valid;
    t_err                         r_err;
    t_err                         n_err;
    logic signed [ANGLE_W-1:0]    m_roll, m_pitch, m_head, t_roll, t_pitch, t_head;
    logic signed [DEG_W-1:0]      deg_m, deg_t;
    logic signed [D_W-1:0]        deg_d;
    logic [U_W-1:0]               u_red;

    function automatic logic signed [DEG_W-1:0] trunc_deg(logic signed [ANGLE_W-1:0] x);
        logic signed [ANGLE_W-1:0] fl;
        logic                      up;
        fl = x >>> ANGLE_FRAC_BITS;
        up = x[ANGLE_W-1] && ((x & FRAC_MASK) != '0);
        return DEG_W'(fl) + DEG_W'(up);
    endfunction

    assign m_roll  = i_data[0*ANGLE_W +: ANGLE_W];
    assign m_pitch = i_data[1*ANGLE_W +: ANGLE_W];
    assign m_head  = i_data[2*ANGLE_W +: ANGLE_W];
    assign t_roll  = i_data[3*ANGLE_W +: ANGLE_W];
    assign t_pitch = i_data[4*ANGLE_W +: ANGLE_W];
    assign t_head  = i_data[5*ANGLE_W +: ANGLE_W];

    assign deg_m = trunc_deg(m_head);
    assign deg_t = trunc_deg(t_head);
    assign deg_d = $signed({deg_m[DEG_W-1], deg_m}) - $signed({deg_t[DEG_W-1], deg_t});

    // floor modulo 360 by conditional subtraction of 360*2^j
    always_comb begin
        u_red = U_W'(int'(deg_d) + 180 + (360 << J));
        for (int j = J; j >= 0; j--) begin
            if (u_red >= U_W'(360 << j)) begin
                u_red = u_red - U_W'(360 << j);
            end
        end
    end

    always_comb begin
        n_err.roll  = $signed({{(ERR_W-ANGLE_W){m_roll[ANGLE_W-1]}}, m_roll})
                    - $signed({{(ERR_W-ANGLE_W){t_roll[ANGLE_W-1]}}, t_roll});
        n_err.pitch = $signed({{(ERR_W-ANGLE_W){m_pitch[ANGLE_W-1]}}, m_pitch})
                    - $signed({{(ERR_W-ANGLE_W){t_pitch[ANGLE_W-1]}}, t_pitch});
        n_err.head  = HEAD_W'(u_red - U_W'(180));
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_err   = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_err <= n_err;
        end
    end

endmodule

[src/tap_queue.sv]
// ----------------------------------------------------------------------------
// tap_queue
// Short FIFO of error records between front and back.
// ----------------------------------------------------------------------------
module tap_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  tap_pkg::t_err i_err,
    output logic          o_valid,
    input  logic          i_ready,
    output tap_pkg::t_err o_err
);
    import tap_pkg::*;

    t_err              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_count;
    logic              push, pop;

    assign o_ready = r_count != (QPTR_W+1)'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_err   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_err;
        end
    end

endmodule

[src/tap_axis.sv]
// ----------------------------------------------------------------------------
// tap_axis
// One PID axis: products, saturating integral, scaled and saturated sum.
// ----------------------------------------------------------------------------
module tap_axis (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tap_pkg::t_pipe_ctl               i_ctl,
    input  tap_pkg::t_gains                  i_gains,
    input  logic signed [tap_pkg::ERR_W-1:0] i_err,
    output logic signed [tap_pkg::OUT_W-1:0] o_drive
);
    import tap_pkg::*;

    localparam int P_W   = GAIN_W + 1 + ERR_W;
    localparam int KD_W  = P_W + 1;
    localparam int PDS_W = KD_W + 1;
    localparam int SHR   = (TOTAL_FRAC >= OUT_FRAC) ? TOTAL_FRAC - OUT_FRAC : 0;
    localparam int SHL   = (TOTAL_FRAC >= OUT_FRAC) ? 0 : OUT_FRAC - TOTAL_FRAC;
    localparam int S_W   = ((ACC_W > PDS_W) ? ACC_W : PDS_W) + 1 + SHL;

    logic signed [ERR_W-1:0] r_prev;
    logic signed [P_W-1:0]   r_kp_e, r_ki_e;
    logic signed [KD_W-1:0]  r_kd_d;
    logic signed [PDS_W-1:0] r_pd;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [OUT_W-1:0] r_drive;

    logic signed [GAIN_W:0]  kp_s, ki_s, kd_s;
    logic signed [ERR_W:0]   diff;
    logic signed [ACC_W:0]   acc_sum;
    logic signed [ACC_W-1:0] n_acc;
    logic signed [S_W-1:0]   tot, scaled;
    logic signed [OUT_W-1:0] n_drive;
    logic [S_W-OUT_W:0]      hi;

    assign kp_s = $signed({1'b0, i_gains.kp});
    assign ki_s = $signed({1'b0, i_gains.ki});
    assign kd_s = $signed({1'b0, i_gains.kd});
    assign diff = i_err - r_prev;

    always_comb begin
        acc_sum = r_acc + r_ki_e;
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
            n_acc = {acc_sum[ACC_W], {(ACC_W-1){~acc_sum[ACC_W]}}};
        end else begin
            n_acc = acc_sum[ACC_W-1:0];
        end
    end

    always_comb begin
        tot = r_acc + r_pd;
        if (TOTAL_FRAC >= OUT_FRAC) begin
            scaled = tot >>> SHR;
        end else begin
            scaled = tot <<< SHL;
        end
        hi = scaled[S_W-1:OUT_W-1];
        if ((&hi) || !(|hi)) begin
            n_drive = scaled[OUT_W-1:0];
        end else begin
            n_drive = {scaled[S_W-1], {(OUT_W-1){~scaled[S_W-1]}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_acc  <= '0;
        end else begin
            if (i_ctl.load_a) begin
                r_prev <= i_err;
            end
            if (i_ctl.load_b) begin
                r_acc <= n_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_a) begin
            r_kp_e <= kp_s * i_err;
            r_ki_e <= ki_s * i_err;
            r_kd_d <= kd_s * diff;
        end
        if (i_ctl.load_b) begin
            r_pd <= r_kp_e + r_kd_d;
        end
        if (i_ctl.load_c) begin
            r_drive <= n_drive;
        end
    end

    assign o_drive = r_drive;

endmodule

[src/tap_back.sv]
// ----------------------------------------------------------------------------
// tap_back
// Three-stage PID pipeline for the three axes with registered result.
// ----------------------------------------------------------------------------
module tap_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  tap_pkg::t_err                     i_err,
    input  tap_pkg::t_gains                   i_roll_gains,
    input  tap_pkg::t_gains                   i_pitch_gains,
    input  tap_pkg::t_gains                   i_heading_gains,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [tap_pkg::OUT_W-1:0]  o_roll,
    output logic signed [tap_pkg::OUT_W-1:0]  o_pitch,
    output logic signed [tap_pkg::OUT_W-1:0]  o_heading,
    output logic signed [tap_pkg::HEAD_W-1:0] o_head_err
);
    import tap_pkg::*;

    logic                     r_va, r_vb, r_vc;
    logic signed [HEAD_W-1:0] r_he_a, r_he_b, r_he_c;
    logic                     en_a, en_b, en_c;
    t_pipe_ctl                ctl;
    logic signed [ERR_W-1:0]  head_scaled;

    assign en_c = !r_vc || i_ready;
    assign en_b = !r_vb || en_c;
    assign en_a = !r_va || en_b;

    assign ctl.load_a = en_a && i_valid;
    assign ctl.load_b = en_b && r_va;
    assign ctl.load_c = en_c && r_vb;

    assign o_ready = en_a;

    assign head_scaled = $signed({{(ERR_W-HEAD_W){i_err.head[HEAD_W-1]}}, i_err.head})
                         <<< ANGLE_FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (en_a) begin
                r_va <= i_valid;
            end
            if (en_b) begin
                r_vb <= r_va;
            end
            if (en_c) begin
                r_vc <= r_vb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.load_a) begin
            r_he_a <= i_err.head;
        end
        if (ctl.load_b) begin
            r_he_b <= r_he_a;
        end
        if (ctl.load_c) begin
            r_he_c <= r_he_b;
        end
    end

    tap_axis u_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_gains (i_roll_gains),
        .i_err   (i_err.roll),
        .o_drive (o_roll)
    );

    tap_axis u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_gains (i_pitch_gains),
        .i_err   (i_err.pitch),
        .o_drive (o_pitch)
    );

    tap_axis u_heading (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_gains (i_heading_gains),
        .i_err   (head_scaled),
        .o_drive (o_heading)
    );

    assign o_valid    = r_vc;
    assign o_head_err = r_he_c;

endmodule

[src/three_axis_attitude_pid.sv]
// ----------------------------------------------------------------------------
// three_axis_attitude_pid
// Roll/pitch/yaw PID with saturating integrals and wrapped yaw error.
//
// channel   dir  handshake                        beat contents
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready  measured r/p/y, target r/p/y
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready  drives r/p/y, yaw error
// cfg       in   i_cfg_valid/o_cfg_ready          gain register index, data
//
// One beat per cycle unless m_axis stalls; stages: front register,
// queue, multiply, integrate, scale/saturate. The 4-entry queue absorbs
// output stalls so the front keeps taking beats. Synchronous active-low
// reset clears gains to default, integrals and previous errors to zero.
// ----------------------------------------------------------------------------
module three_axis_attitude_pid (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // measured_roll, measured_pitch, measured_heading,
    // target_roll, target_pitch, target_heading (16 bits each)
    input  logic [tap_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // roll_drive, pitch_drive, heading_drive (32 each), heading_error_out (9), zero pad
    output logic [tap_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tap_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tap_pkg::GAINS_W-1:0]       i_cfg_data
);
    import tap_pkg::*;

    localparam int PAD_W = OUT_TDATA_W - OUT_FIELD_W;

    t_gains                  r_roll_gains, r_pitch_gains, r_heading_gains;
    logic                    f_valid, f_ready, q_valid, q_ready;
    t_err                    f_err, q_err;
    logic signed [OUT_W-1:0] roll_drive, pitch_drive, heading_drive;
    logic signed [HEAD_W-1:0] head_err;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roll_gains    <= GAINS_RESET;
            r_pitch_gains   <= GAINS_RESET;
            r_heading_gains <= GAINS_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROLL: begin
                    r_roll_gains <= i_cfg_data;
                end
                CFG_PITCH: begin
                    r_pitch_gains <= i_cfg_data;
                end
                CFG_HEADING: begin
                    r_heading_gains <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    tap_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (i_s_axis_tdata),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_err   (f_err)
    );

    tap_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_err   (f_err),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_err   (q_err)
    );

    tap_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (q_valid),
        .o_ready         (q_ready),
        .i_err           (q_err),
        .i_roll_gains    (r_roll_gains),
        .i_pitch_gains   (r_pitch_gains),
        .i_heading_gains (r_heading_gains),
        .o_valid         (o_m_axis_tvalid),
        .i_ready         (i_m_axis_tready),
        .o_roll          (roll_drive),
        .o_pitch         (pitch_drive),
        .o_heading       (heading_drive),
        .o_head_err      (head_err)
    );

    assign o_m_axis_tdata = {{PAD_W{1'b0}}, head_err, heading_drive, pitch_drive, roll_drive};

endmodule

[src/tap_checker.sv]
// ----------------------------------------------------------------------------
// tap_checker
// Port-level checks of the attitude PID, bound to the top level.
// ----------------------------------------------------------------------------
`include "three_axis_attitude_pid_macros.svh"

module tap_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [tap_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import tap_pkg::*;

    logic stalled;
    logic head_ok;
    logic pad_ok;
    logic signed [HEAD_W-1:0] head_err;

    assign stalled  = o_m_axis_tvalid && !i_m_axis_tready;
    assign head_err = o_m_axis_tdata[3*OUT_W +: HEAD_W];
    assign head_ok  = (head_err >= -9'sd180) && (head_err <= 9'sd179);
    assign pad_ok   = o_m_axis_tdata[OUT_TDATA_W-1:OUT_FIELD_W] == '0;

    `TAP_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, stalled, o_m_axis_tvalid, "result beat dropped")
    `TAP_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, stalled, $stable(o_m_axis_tdata), "beat changed")
    `TAP_ASSERT_IMP(a_head_rng, i_clk, i_rst_n, o_m_axis_tvalid, head_ok, "yaw error out of range")
    `TAP_ASSERT_IMP(a_pad_zero, i_clk, i_rst_n, o_m_axis_tvalid, pad_ok, "pad bits set")

endmodule

bind three_axis_attitude_pid tap_checker u_tap_checker (.*);

[tb/three_axis_attitude_pid_test.sv]
// ----------------------------------------------------------------------------
// three_axis_attitude_pid_test
// Self-checking bench for the three-axis attitude PID.
//
// Attitude beats go in on s_axis with random gaps. Drive beats come back on
// m_axis with random stalls. Each drive beat is checked against a local PID
// model that keeps its own gains, integrals and previous errors. Covered:
// angle and yaw-wrap corners, gain extremes, random gain phases, writes to
// the unused register index, back-to-back traffic and integral windup into
// both output clamps.
// ----------------------------------------------------------------------------
module three_axis_attitude_pid_test;
    import tap_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int     DUT_LATENCY    = 5;
    localparam int     SETTLE_CYCLES  = 2 * DUT_LATENCY;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     MAX_REPORTS    = 10;
    localparam longint INTEG_MAX      = (longint'(1) <<< (ACC_W - 1)) - 1;
    localparam longint INTEG_MIN      = -INTEG_MAX - 1;
    localparam longint DRIVE_MAX      = 64'sd2147483647;
    localparam longint DRIVE_MIN      = -64'sd2147483648;
    localparam longint HEAD_SCALE     = longint'(1) <<< ANGLE_FRAC_BITS;
    localparam logic [GAINS_W-1:0] GAINS_ALL_ONES = '1;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] tgt_heading;
        logic signed [ANGLE_W-1:0] tgt_pitch;
        logic signed [ANGLE_W-1:0] tgt_roll;
        logic signed [ANGLE_W-1:0] meas_heading;
        logic signed [ANGLE_W-1:0] meas_pitch;
        logic signed [ANGLE_W-1:0] meas_roll;
    } attitude_t;

    typedef struct {
        logic signed [OUT_W-1:0]  roll;
        logic signed [OUT_W-1:0]  pitch;
        logic signed [OUT_W-1:0]  heading;
        logic signed [HEAD_W-1:0] head_err;
    } drive_beat_t;

    logic                     i_clk           = 1'b0;
    logic                     i_rst_n         = 1'b0;
    logic                     i_s_axis_tvalid = 1'b0;
    logic                     o_s_axis_tready;
    logic [IN_TDATA_W-1:0]    i_s_axis_tdata  = '0;
    logic                     o_m_axis_tvalid;
    logic                     i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]   o_m_axis_tdata;
    logic                     i_cfg_valid     = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index     = '0;
    logic [GAINS_W-1:0]       i_cfg_data      = '0;

    // model state
    logic [GAINS_W-1:0] gain_set [3] = '{GAINS_RESET, GAINS_RESET, GAINS_RESET};
    longint             integ_acc [3] = '{0, 0, 0};
    longint             prev_err [3]  = '{0, 0, 0};

    drive_beat_t pending_drives [$];
    int          mismatch_count = 0;
    int          out_stall      = 0;
    int          idle_cycles    = 0;
    bit          no_idle        = 1'b0;

    three_axis_attitude_pid u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic int as_int(logic signed [ANGLE_W-1:0] v);
        return v;
    endfunction

    // truncate toward zero to whole degrees
    function automatic int whole_deg(int x);
        if (x >= 0) begin
            return x >>> ANGLE_FRAC_BITS;
        end
        return -((-x) >>> ANGLE_FRAC_BITS);
    endfunction

    function automatic logic signed [OUT_W-1:0] axis_drive(int ax, longint err);
        longint kp, ki, kd, integ, sum;
        t_gains g;
        g  = gain_set[ax];
        kp = {44'd0, g.kp};
        ki = {44'd0, g.ki};
        kd = {44'd0, g.kd};
        integ = integ_acc[ax] + ki * err;
        if (integ > INTEG_MAX) begin
            integ = INTEG_MAX;
        end
        if (integ < INTEG_MIN) begin
            integ = INTEG_MIN;
        end
        integ_acc[ax] = integ;
        sum = kp * err + integ + kd * (err - prev_err[ax]);
        prev_err[ax] = err;
        sum = sum >>> (TOTAL_FRAC - OUT_FRAC);
        if (sum > DRIVE_MAX) begin
            sum = DRIVE_MAX;
        end
        if (sum < DRIVE_MIN) begin
            sum = DRIVE_MIN;
        end
        return sum[OUT_W-1:0];
    endfunction

    function automatic drive_beat_t predict_pid_drives(attitude_t a);
        drive_beat_t d;
        int          yaw_diff, wrapped;
        yaw_diff = whole_deg(as_int(a.meas_heading)) - whole_deg(as_int(a.tgt_heading));
        wrapped  = (yaw_diff + 180) % 360;
        if (wrapped < 0) begin
            wrapped += 360;
        end
        wrapped   -= 180;
        d.roll     = axis_drive(CFG_ROLL, as_int(a.meas_roll) - as_int(a.tgt_roll));
        d.pitch    = axis_drive(CFG_PITCH, as_int(a.meas_pitch) - as_int(a.tgt_pitch));
        d.heading  = axis_drive(CFG_HEADING, longint'(wrapped) * HEAD_SCALE);
        d.head_err = wrapped[HEAD_W-1:0];
        return d;
    endfunction

    function automatic attitude_t make_beat(int mr, int mp, int mh, int tr, int tp, int th);
        attitude_t b;
        b.meas_roll    = mr[ANGLE_W-1:0];
        b.meas_pitch   = mp[ANGLE_W-1:0];
        b.meas_heading = mh[ANGLE_W-1:0];
        b.tgt_roll     = tr[ANGLE_W-1:0];
        b.tgt_pitch    = tp[ANGLE_W-1:0];
        b.tgt_heading  = th[ANGLE_W-1:0];
        return b;
    endfunction

    function automatic int random_angle();
        int v;
        case ($urandom_range(0, 9))
            0: begin
                v = $urandom;
            end
            1: begin
                case ($urandom_range(0, 4))
                    0: v = 23040;
                    1: v = -23040;
                    2: v = 32767;
                    3: v = -32768;
                    default: v = 0;
                endcase
            end
            default: begin
                v = int'($urandom_range(0, 46080)) - 23040;
            end
        endcase
        return v;
    endfunction

    // targets often sit close to the measurement so errors stay small
    function automatic attitude_t random_attitude();
        int m [3];
        int t [3];
        foreach (m[k]) begin
            m[k] = random_angle();
            if ($urandom_range(0, 2) == 0) begin
                t[k] = m[k] + int'($urandom_range(0, 512)) - 256;
            end else begin
                t[k] = random_angle();
            end
        end
        return make_beat(m[0], m[1], m[2], t[0], t[1], t[2]);
    endfunction

    function automatic logic [GAINS_W-1:0] random_gains();
        logic [63:0] raw;
        t_gains      g;
        raw = {$urandom, $urandom};
        g   = raw[GAINS_W-1:0];
        if ($urandom_range(0, 3) == 0) begin
            g.kp = $urandom_range(0, 1) ? '1 : '0;
        end
        if ($urandom_range(0, 3) == 0) begin
            g.ki = $urandom_range(0, 1) ? '1 : '0;
        end
        if ($urandom_range(0, 3) == 0) begin
            g.kd = $urandom_range(0, 1) ? '1 : '0;
        end
        return g;
    endfunction

    task automatic send_attitude(attitude_t beat);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= beat;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_drives.push_back(predict_pid_drives(beat));
    endtask

    // gains change only with the pipeline empty
    task automatic write_gains(logic [CFG_IDX_W-1:0] idx, logic [GAINS_W-1:0] value);
        i_s_axis_tvalid <= 1'b0;
        while (pending_drives.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx != CFG_SPARE) begin
            gain_set[idx] = value;
        end
    endtask

    task automatic write_all_gains(logic [GAINS_W-1:0] r, logic [GAINS_W-1:0] p,
                                   logic [GAINS_W-1:0] h);
        write_gains(CFG_ROLL, r);
        write_gains(CFG_PITCH, p);
        write_gains(CFG_HEADING, h);
    endtask

    task automatic send_random_attitudes(int count);
        repeat (count) send_attitude(random_attitude());
    endtask

    // range extremes, full 16-bit patterns, yaw wrap and truncation corners
    task automatic send_angle_corners();
        send_attitude(make_beat(0, 0, 0, 0, 0, 0));
        send_attitude(make_beat(23040, -23040, 23040, -23040, 23040, 0));
        send_attitude(make_beat(32767, -32768, 32767, -32768, 32767, -32768));
        send_attitude(make_beat(-32768, 32767, -32768, 32767, -32768, 32767));
        send_attitude(make_beat(100, -100, 22912, 100, -100, -23040));
        send_attitude(make_beat(-5, 5, -23040, 0, 0, 0));
        send_attitude(make_beat(5, -5, 23040, 0, 0, 0));
        send_attitude(make_beat(1, 1, -23040, -1, -1, 23040));
        send_attitude(make_beat(-1, 0, -64, 1, 0, 64));
        send_attitude(make_beat(0, -1, -129, 0, 1, 127));
        send_attitude(make_beat(300, 300, 0, -300, -300, 23168));
        send_attitude(make_beat(-300, -300, -23168, 300, 300, 0));
    endtask

    task automatic test_directed_angles();
        send_angle_corners();
        write_all_gains(GAINS_ALL_ONES, GAINS_ALL_ONES, GAINS_ALL_ONES);
        send_angle_corners();
    endtask

    task automatic test_gain_extremes();
        t_gains g;
        write_all_gains('0, '0, '0);
        send_random_attitudes(60);
        g.kp = '1;
        g.ki = '0;
        g.kd = '1;
        write_all_gains(g, GAINS_RESET, g);
        send_random_attitudes(60);
        write_all_gains(GAINS_RESET, GAINS_RESET, GAINS_RESET);
        send_random_attitudes(40);
    endtask

    task automatic test_random_gains();
        repeat (4) begin
            write_all_gains(random_gains(), random_gains(), random_gains());
            send_random_attitudes(80);
        end
    endtask

    task automatic test_spare_index();
        write_gains(CFG_SPARE, random_gains());
        send_random_attitudes(30);
    endtask

    task automatic test_back_to_back();
        write_all_gains(random_gains(), random_gains(), random_gains());
        no_idle = 1'b1;
        send_random_attitudes(150);
        no_idle = 1'b0;
        send_random_attitudes(30);
    endtask

    // max ki with max error pushes roll drive to the upper clamp, pitch to the lower
    task automatic test_integral_windup();
        t_gains g;
        g    = random_gains();
        g.ki = '1;
        write_all_gains(g, g, GAINS_ALL_ONES);
        no_idle = 1'b1;
        repeat (1150) begin
            send_attitude(make_beat(32767, -32768, random_angle(),
                                    -32768, 32767, random_angle()));
        end
        no_idle = 1'b0;
        repeat (30) begin
            send_attitude(make_beat(-32768, 32767, random_angle(),
                                    32767, -32768, random_angle()));
        end
    endtask

    always @(posedge i_clk) begin : drive_monitor
        drive_beat_t got, want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            out_stall = 0;
        end else if (o_m_axis_tvalid && i_m_axis_tready) begin
            got.roll     = o_m_axis_tdata[OUT_W-1:0];
            got.pitch    = o_m_axis_tdata[2*OUT_W-1:OUT_W];
            got.heading  = o_m_axis_tdata[3*OUT_W-1:2*OUT_W];
            got.head_err = o_m_axis_tdata[3*OUT_W+HEAD_W-1:3*OUT_W];
            if (pending_drives.size() == 0) begin
                if (mismatch_count < MAX_REPORTS) begin
                    $display("unexpected drive beat: roll %0d pitch %0d yaw %0d yaw_err %0d",
                             got.roll, got.pitch, got.heading, got.head_err);
                end
                mismatch_count++;
            end else begin
                want = pending_drives.pop_front();
                if (got.roll !== want.roll || got.pitch !== want.pitch ||
                    got.heading !== want.heading || got.head_err !== want.head_err) begin
                    if (mismatch_count < MAX_REPORTS) begin
                        $display("drive mismatch: exp roll %0d pitch %0d yaw %0d yaw_err %0d",
                                 want.roll, want.pitch, want.heading, want.head_err);
                        $display("                got roll %0d pitch %0d yaw %0d yaw_err %0d",
                                 got.roll, got.pitch, got.heading, got.head_err);
                    end
                    mismatch_count++;
                end
            end
            out_stall = no_idle ? 0 : $urandom_range(0, 12);
            i_m_axis_tready <= (out_stall == 0);
        end else if (out_stall > 0) begin
            out_stall--;
            if (out_stall == 0) begin
                i_m_axis_tready <= 1'b1;
            end
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_angles();
        test_gain_extremes();
        test_random_gains();
        test_spare_index();
        test_back_to_back();
        test_integral_windup();
        i_s_axis_tvalid <= 1'b0;
        while (pending_drives.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_drives.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
